// File: hw/rtl/rdbsep_pkg.sv
// Shared types and constants for the serialized string element parser.
// Holds the item structs, phase and kind codes and header byte masks.
// No dependencies.
`timescale 1ns / 1ps

package rdbsep_pkg;

    // Default width of length registers (range 32 to 64)
    localparam int LEN_BITS_DEFAULT = 64;

    // Header byte fields
    localparam logic [7:0] HDR_TOP_MASK = 8'hC0;
    localparam logic [7:0] HDR_LOW_MASK = 8'h3F;

    // Top two bits of a length header
    localparam logic [1:0] TOP_LEN6  = 2'd0;
    localparam logic [1:0] TOP_LEN14 = 2'd1;
    localparam logic [1:0] TOP_LONG  = 2'd2;
    localparam logic [1:0] TOP_ENC   = 2'd3;

    // Long length markers
    localparam logic [7:0] HDR_LEN32 = 8'h80;
    localparam logic [7:0] HDR_LEN64 = 8'h81;

    // Encoding codes carried in the low six bits
    localparam logic [5:0] ENC_INT8       = 6'd0;
    localparam logic [5:0] ENC_INT16      = 6'd1;
    localparam logic [5:0] ENC_INT32      = 6'd2;
    localparam logic [5:0] ENC_COMPRESSED = 6'd3;

    // Byte counts of length and integer fields
    localparam logic [3:0] NBYTES_1 = 4'd1;
    localparam logic [3:0] NBYTES_2 = 4'd2;
    localparam logic [3:0] NBYTES_4 = 4'd4;
    localparam logic [3:0] NBYTES_8 = 4'd8;

    typedef enum logic [1:0] {
        KIND_RAW        = 2'd0,
        KIND_INT        = 2'd1,
        KIND_COMPRESSED = 2'd2
    } kind_t;

    typedef enum logic [7:0] {
        PH_HDR      = 8'b0000_0001,
        PH_HDR_EXT  = 8'b0000_0010,
        PH_CLEN     = 8'b0000_0100,
        PH_CLEN_EXT = 8'b0000_1000,
        PH_OLEN     = 8'b0001_0000,
        PH_OLEN_EXT = 8'b0010_0000,
        PH_INT      = 8'b0100_0000,
        PH_PAYLOAD  = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0]         byte_out;
        logic               element_end;
        logic [1:0]         element_kind;
        logic [63:0]        decoded_length;
        logic [63:0]        plain_length;
        logic signed [31:0] int_value;
        logic               parse_error;
    } out_item_t;

endpackage

// File: hw/rtl/rdbsep_stream_if.sv
// Valid/ready stream channel carrying one item of a given struct type.
// Used for both sides of the parser; payload types come from rdbsep_pkg.
`timescale 1ns / 1ps

interface rdbsep_stream_if #(
    parameter type item_t = logic
);

    logic  valid;
    logic  ready;
    item_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );

endinterface

// File: hw/rtl/rdb_string_encoding_parser_core.sv
// Byte-serial parser for serialized string elements; top level.
// Depends on rdbsep_pkg and rdbsep_stream_if.
//
// Every accepted byte comes back out verbatim, one result item per input item,
// with the byte that completes an element marked by its kind (raw, integer,
// compressed), its lengths and its integer value; a bad length or encoding
// code raises parse_error and returns the parser to the header phase. The
// parser takes one byte per clock unless the result side stalls: the phase
// update, the length shift with saturation and the payload countdown all fit
// between the state registers and the single result register, so a byte may
// be accepted in every cycle. The result is registered and appears in the
// cycle after its byte is accepted. The result register accepts a new byte
// while the present result is taken, so throughput stays at one item per cycle
// unless the result side stalls. Lengths are held in LEN_BITS-wide registers
// and saturate at 2^LEN_BITS - 1; the 64-bit length outputs are zero-extended.
`timescale 1ns / 1ps

module rdb_string_encoding_parser_core
    import rdbsep_pkg::*;
#(
    parameter int LEN_BITS = LEN_BITS_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    rdbsep_stream_if.sink          stream,
    rdbsep_stream_if.source        result
);

    localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

    // Parser state
    phase_t              phase_reg, phase_next;
    logic [7:0]          header_reg, header_next;
    logic [LEN_BITS-1:0] shift_reg, shift_next;
    logic [3:0]          fbl_reg, fbl_next;
    logic [LEN_BITS-1:0] payload_left_reg, payload_left_next;
    logic [LEN_BITS-1:0] stored_reg, stored_next;
    logic [31:0]         accum_reg, accum_next;

    // Result register
    out_item_t res_reg;
    out_item_t res_next;
    logic      res_valid_reg;

    logic       accept;
    logic [7:0] b;

    // Working signals of the step logic
    logic                do_start;
    phase_t              start_ctx;
    logic                do_finish;
    phase_t              fin_ctx;
    logic [LEN_BITS-1:0] fin_val;
    logic                do_fail;
    logic [1:0]          top;
    logic [5:0]          low;
    logic [3:0]          fbl_dec;
    logic [3:0]          int_total;
    logic [3:0]          int_pos;
    logic [31:0]         int_acc;
    logic [31:0]         int_ext;

    assign b            = stream.payload.data_byte;
    assign stream.ready = !res_valid_reg || result.ready;
    assign accept       = stream.valid && stream.ready;
    assign top          = b[7:6];
    assign low          = b[5:0] & HDR_LOW_MASK[5:0];
    assign fbl_dec      = (fbl_reg != 4'd0) ? (fbl_reg - 4'd1) : 4'd0;

    // Integer field: total width from the header code, byte lane from count
    always_comb
    begin
        case (header_reg[5:0])
            ENC_INT32: int_total = NBYTES_4;
            ENC_INT16: int_total = NBYTES_2;
            default:   int_total = NBYTES_1;
        endcase
        int_pos = int_total - fbl_reg;
        int_acc = accum_reg;
        case (int_pos[1:0])
            2'd0:    int_acc[7:0]   = accum_reg[7:0]   | b;
            2'd1:    int_acc[15:8]  = accum_reg[15:8]  | b;
            2'd2:    int_acc[23:16] = accum_reg[23:16] | b;
            default: int_acc[31:24] = accum_reg[31:24] | b;
        endcase
        int_ext = int_acc;
        if (int_total == NBYTES_1 && int_acc[7])
        begin
            int_ext[31:8] = '1;
        end
        else if (int_total == NBYTES_2 && int_acc[15])
        begin
            int_ext[31:16] = '1;
        end
    end

    // Step the parser by one byte
    always_comb
    begin
        phase_next        = phase_reg;
        header_next       = header_reg;
        shift_next        = shift_reg;
        fbl_next          = fbl_reg;
        payload_left_next = payload_left_reg;
        stored_next       = stored_reg;
        accum_next        = accum_reg;

        res_next                = '0;
        res_next.byte_out       = b;
        res_next.element_kind   = KIND_RAW;

        do_start  = 1'b0;
        start_ctx = PH_HDR;
        do_finish = 1'b0;
        fin_ctx   = PH_HDR;
        fin_val   = '0;
        do_fail   = 1'b0;

        case (phase_reg)
            PH_CLEN, PH_OLEN:
            begin
                do_start  = 1'b1;
                start_ctx = phase_reg;
            end
            PH_HDR_EXT, PH_CLEN_EXT, PH_OLEN_EXT:
            begin
                // Shift in one length byte, saturating
                if (shift_reg[LEN_BITS-1 -: 8] != 8'd0)
                begin
                    shift_next = LEN_MAX;
                end
                else
                begin
                    shift_next = {shift_reg[LEN_BITS-9:0], b};
                end
                fbl_next = fbl_dec;
                if (fbl_dec == 4'd0)
                begin
                    do_finish = 1'b1;
                    fin_val   = shift_next;
                    if (phase_reg == PH_CLEN_EXT)
                    begin
                        fin_ctx = PH_CLEN;
                    end
                    else if (phase_reg == PH_OLEN_EXT)
                    begin
                        fin_ctx = PH_OLEN;
                    end
                    else
                    begin
                        fin_ctx = PH_HDR;
                    end
                end
            end
            PH_INT:
            begin
                accum_next = int_acc;
                fbl_next   = fbl_dec;
                if (fbl_dec == 4'd0)
                begin
                    res_next.element_end  = 1'b1;
                    res_next.element_kind = KIND_INT;
                    res_next.int_value    = int_ext;
                    phase_next            = PH_HDR;
                end
            end
            PH_PAYLOAD:
            begin
                if (payload_left_reg <= LEN_BITS'(1))
                begin
                    payload_left_next              = '0;
                    res_next.element_end           = 1'b1;
                    res_next.decoded_length        = 64'(stored_reg);
                    if ((header_reg & HDR_TOP_MASK) == HDR_TOP_MASK)
                    begin
                        res_next.element_kind = KIND_COMPRESSED;
                        res_next.plain_length = 64'(shift_reg);
                    end
                    phase_next = PH_HDR;
                end
                else
                begin
                    payload_left_next = payload_left_reg - LEN_BITS'(1);
                end
            end
            default:
            begin
                // Element header: start from a clean state
                phase_next        = PH_HDR;
                shift_next        = '0;
                fbl_next          = 4'd0;
                payload_left_next = '0;
                stored_next       = '0;
                accum_next        = '0;
                header_next       = b;
                do_start          = 1'b1;
                start_ctx         = PH_HDR;
            end
        endcase

        // Decode the first byte of a length or encoding header
        if (do_start)
        begin
            case (top)
                TOP_LEN6:
                begin
                    do_finish = 1'b1;
                    fin_ctx   = start_ctx;
                    fin_val   = LEN_BITS'(low);
                end
                TOP_LEN14:
                begin
                    shift_next = LEN_BITS'(low);
                    fbl_next   = NBYTES_1;
                    phase_next = (start_ctx == PH_CLEN) ? PH_CLEN_EXT :
                                 (start_ctx == PH_OLEN) ? PH_OLEN_EXT : PH_HDR_EXT;
                end
                TOP_LONG:
                begin
                    if (b inside {HDR_LEN32, HDR_LEN64})
                    begin
                        shift_next = '0;
                        fbl_next   = (b == HDR_LEN32) ? NBYTES_4 : NBYTES_8;
                        phase_next = (start_ctx == PH_CLEN) ? PH_CLEN_EXT :
                                     (start_ctx == PH_OLEN) ? PH_OLEN_EXT : PH_HDR_EXT;
                    end
                    else
                    begin
                        do_fail = 1'b1;
                    end
                end
                default:
                begin
                    if (start_ctx != PH_HDR)
                    begin
                        // Sub-lengths of a compressed element take 11 as a 6-bit length
                        do_finish = 1'b1;
                        fin_ctx   = start_ctx;
                        fin_val   = LEN_BITS'(low);
                    end
                    else if (low inside {ENC_INT8, ENC_INT16, ENC_INT32})
                    begin
                        accum_next = '0;
                        fbl_next   = (low == ENC_INT32) ? NBYTES_4 :
                                     (low == ENC_INT16) ? NBYTES_2 : NBYTES_1;
                        phase_next = PH_INT;
                    end
                    else if (low == ENC_COMPRESSED)
                    begin
                        phase_next = PH_CLEN;
                    end
                    else
                    begin
                        do_fail = 1'b1;
                    end
                end
            endcase
        end

        // Complete a length field
        if (do_finish)
        begin
            if (fin_ctx == PH_CLEN)
            begin
                stored_next = fin_val;
                phase_next  = PH_OLEN;
            end
            else if (fin_ctx == PH_OLEN)
            begin
                shift_next = fin_val;
                if (stored_reg == '0)
                begin
                    res_next.element_end  = 1'b1;
                    res_next.element_kind = KIND_COMPRESSED;
                    res_next.plain_length = 64'(fin_val);
                    phase_next            = PH_HDR;
                end
                else
                begin
                    payload_left_next = stored_reg;
                    phase_next        = PH_PAYLOAD;
                end
            end
            else
            begin
                stored_next = fin_val;
                if (fin_val == '0)
                begin
                    res_next.element_end = 1'b1;
                    phase_next           = PH_HDR;
                end
                else
                begin
                    payload_left_next = fin_val;
                    phase_next        = PH_PAYLOAD;
                end
            end
        end

        // Drop everything on a bad code
        if (do_fail)
        begin
            phase_next           = PH_HDR;
            header_next          = '0;
            shift_next           = '0;
            fbl_next             = 4'd0;
            payload_left_next    = '0;
            stored_next          = '0;
            accum_next           = '0;
            res_next             = '0;
            res_next.byte_out    = b;
            res_next.parse_error = 1'b1;
        end
    end

    // Advance parser state on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HDR;
            header_reg       <= '0;
            shift_reg        <= '0;
            fbl_reg          <= '0;
            payload_left_reg <= '0;
            stored_reg       <= '0;
            accum_reg        <= '0;
        end
        else if (accept)
        begin
            phase_reg        <= phase_next;
            header_reg       <= header_next;
            shift_reg        <= shift_next;
            fbl_reg          <= fbl_next;
            payload_left_reg <= payload_left_next;
            stored_reg       <= stored_next;
            accum_reg        <= accum_next;
        end
    end

    // Hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid   = res_valid_reg;
    assign result.payload = res_reg;

endmodule

// File: test/tb_rdb_string_encoding_parser_core.sv
// Self-checking testbench for rdb_string_encoding_parser_core.
// Needs rdbsep_pkg and rdbsep_stream_if; a scoreboard class predicts each result
// item from the accepted bytes, a task feeds the bytes and a process drives result ready.
`timescale 1ns / 1ps

module tb_rdb_string_encoding_parser_core
    import rdbsep_pkg::*;
();

    localparam int STIM_BYTES = 1030;
    localparam int LONG_HOLD  = 300;
    localparam int HOLD_AFTER = 400;
    localparam int DRAIN_WAIT = 4;

    // Track the parse of the byte stream and hold the result items still due
    class element_checker;
        phase_t      phase;
        logic [7:0]  header_byte;
        logic [63:0] len_acc;
        int unsigned bytes_due;
        logic [63:0] payload_due;
        logic [63:0] stored_len;
        logic [31:0] int_acc;
        out_item_t   cur;
        out_item_t   awaited_results[$];
        int unsigned errors;
        int unsigned checked;
        int unsigned raw_seen;
        int unsigned int_seen;
        int unsigned lz_seen;
        int unsigned bad_seen;

        function new();
            clear_state();
            errors   = 0;
            checked  = 0;
            raw_seen = 0;
            int_seen = 0;
            lz_seen  = 0;
            bad_seen = 0;
        endfunction

        function void clear_state();
            phase       = PH_HDR;
            header_byte = '0;
            len_acc     = '0;
            bytes_due   = 0;
            payload_due = '0;
            stored_len  = '0;
            int_acc     = '0;
        endfunction

        function void emit_end(kind_t kind, logic [63:0] dlen, logic [63:0] plen,
                               logic [31:0] ival);
            cur.element_end    = 1'b1;
            cur.element_kind   = kind;
            cur.decoded_length = dlen;
            cur.plain_length   = plen;
            cur.int_value      = ival;
        endfunction

        function void abandon_element();
            clear_state();
            cur.parse_error = 1'b1;
        endfunction

        // Close a length field; ctx is the phase of its first byte
        function void finish_len(phase_t ctx, logic [63:0] v);
            if (ctx == PH_CLEN)
            begin
                stored_len = v;
                phase      = PH_OLEN;
            end
            else if (ctx == PH_OLEN)
            begin
                len_acc = v;
                if (stored_len == 0)
                begin
                    emit_end(KIND_COMPRESSED, '0, v, '0);
                    phase = PH_HDR;
                end
                else
                begin
                    payload_due = stored_len;
                    phase       = PH_PAYLOAD;
                end
            end
            else
            begin
                stored_len = v;
                if (v == 0)
                begin
                    emit_end(KIND_RAW, '0, '0, '0);
                    phase = PH_HDR;
                end
                else
                begin
                    payload_due = v;
                    phase       = PH_PAYLOAD;
                end
            end
        endfunction

        // Decode the first byte of a length header or element header
        function void start_len(phase_t ctx, logic [7:0] b);
            logic [1:0]  top;
            logic [63:0] low;
            top = b[7:6];
            low = {58'd0, b[5:0]};
            if (top == TOP_LEN6)
            begin
                finish_len(ctx, low);
            end
            else if (top == TOP_LEN14)
            begin
                len_acc   = low;
                bytes_due = 1;
                phase     = phase_t'(ctx << 1);
            end
            else if (top == TOP_LONG)
            begin
                if (b inside {HDR_LEN32, HDR_LEN64})
                begin
                    len_acc   = '0;
                    bytes_due = (b == HDR_LEN32) ? 4 : 8;
                    phase     = phase_t'(ctx << 1);
                end
                else
                begin
                    abandon_element();
                end
            end
            else if (ctx != PH_HDR)
            begin
                // inside a compressed element, top bits 11 are a plain 6-bit length
                finish_len(ctx, low);
            end
            else if (b[5:0] inside {ENC_INT8, ENC_INT16, ENC_INT32})
            begin
                int_acc   = '0;
                bytes_due = (b[5:0] == ENC_INT32) ? 4 : int'(b[5:0]) + 1;
                phase     = PH_INT;
            end
            else if (b[5:0] == ENC_COMPRESSED)
            begin
                phase = PH_CLEN;
            end
            else
            begin
                abandon_element();
            end
        endfunction

        // Note an accepted byte and queue the result item it causes
        function void take_byte(logic [7:0] b);
            int unsigned total;
            int unsigned idx;
            logic [31:0] v;
            cur          = '0;
            cur.byte_out = b;
            case (phase)
                PH_CLEN, PH_OLEN: start_len(phase, b);
                PH_HDR_EXT, PH_CLEN_EXT, PH_OLEN_EXT:
                begin
                    if (len_acc > ({64{1'b1}} >> 8))
                        len_acc = {64{1'b1}};
                    else
                        len_acc = {len_acc[55:0], b};
                    if (bytes_due > 0)
                        bytes_due--;
                    if (bytes_due == 0)
                        finish_len(phase_t'(phase >> 1), len_acc);
                end
                PH_INT:
                begin
                    total = (header_byte[5:0] == ENC_INT32) ? 4 :
                            (header_byte[5:0] == ENC_INT16) ? 2 : 1;
                    idx = (total - bytes_due) & 3;
                    int_acc = int_acc | (32'(b) << (8 * idx));
                    if (bytes_due > 0)
                        bytes_due--;
                    if (bytes_due == 0)
                    begin
                        v = int_acc;
                        if (total == 1 && v[7])
                            v[31:8] = '1;
                        else if (total == 2 && v[15])
                            v[31:16] = '1;
                        emit_end(KIND_INT, '0, '0, v);
                        phase = PH_HDR;
                    end
                end
                PH_PAYLOAD:
                begin
                    if (payload_due <= 1)
                    begin
                        payload_due = '0;
                        if ((header_byte & HDR_TOP_MASK) == HDR_TOP_MASK)
                            emit_end(KIND_COMPRESSED, stored_len, len_acc, '0);
                        else
                            emit_end(KIND_RAW, stored_len, '0, '0);
                        phase = PH_HDR;
                    end
                    else
                    begin
                        payload_due--;
                    end
                end
                default:
                begin
                    clear_state();
                    header_byte = b;
                    start_len(PH_HDR, b);
                end
            endcase
            awaited_results.push_back(cur);
        endfunction

        function void check_field(string fname, logic [63:0] want, logic [63:0] got);
            if (got !== want)
            begin
                $error("%s mismatch at result %0d: expected %0h, got %0h",
                       fname, checked, want, got);
                errors++;
            end
        endfunction

        // Compare a result item with the oldest one due
        function void compare_result(out_item_t got);
            out_item_t want;
            if (awaited_results.size() == 0)
            begin
                $error("result item with no accepted byte behind it (byte_out %0h)",
                       got.byte_out);
                errors++;
                return;
            end
            want = awaited_results.pop_front();
            checked++;
            check_field("byte_out", want.byte_out, got.byte_out);
            check_field("element_end", want.element_end, got.element_end);
            check_field("element_kind", want.element_kind, got.element_kind);
            check_field("decoded_length", want.decoded_length, got.decoded_length);
            check_field("plain_length", want.plain_length, got.plain_length);
            check_field("int_value", want.int_value, got.int_value);
            check_field("parse_error", want.parse_error, got.parse_error);
            if (want.parse_error)
                bad_seen++;
            if (want.element_end)
            begin
                if (want.element_kind == KIND_RAW)
                    raw_seen++;
                else if (want.element_kind == KIND_INT)
                    int_seen++;
                else
                    lz_seen++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    rdbsep_stream_if #(.item_t(in_item_t))  in_ch ();
    rdbsep_stream_if #(.item_t(out_item_t)) out_ch ();

    element_checker chk = new();
    logic [7:0]     stim[$];

    rdb_string_encoding_parser_core DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (in_ch),
        .result (out_ch)
    );

    // Clock
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    // Mostly small sizes, rarely a few hundred bytes
    function automatic logic [63:0] pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, 6);
        if (r < 93)
            return $urandom_range(7, 64);
        if (r < 99)
            return $urandom_range(65, 200);
        return $urandom_range(201, 400);
    endfunction

    // Append a length header in a random form that can hold v
    function automatic void put_length(logic [63:0] v, bit inner);
        int form;
        do
            form = $urandom_range(0, 4);
        while (!((form == 0 && v < 64) || (form == 1 && inner && v < 64) ||
                 (form == 2 && v < 16384) || (form == 3 && v < 64'h1_0000_0000) ||
                 form == 4));
        case (form)
            0: stim.push_back({TOP_LEN6, v[5:0]});
            1: stim.push_back({TOP_ENC, v[5:0]});
            2:
            begin
                stim.push_back({TOP_LEN14, v[13:8]});
                stim.push_back(v[7:0]);
            end
            3:
            begin
                stim.push_back(HDR_LEN32);
                for (int i = 3; i >= 0; i--)
                    stim.push_back(v[8*i +: 8]);
            end
            default:
            begin
                stim.push_back(HDR_LEN64);
                for (int i = 7; i >= 0; i--)
                    stim.push_back(v[8*i +: 8]);
            end
        endcase
    endfunction

    function automatic void put_random_bytes(logic [63:0] n);
        for (longint i = 0; i < n; i++)
            stim.push_back(8'($urandom_range(0, 255)));
    endfunction

    // Append one well-formed element with random content, or a broken one
    function automatic void add_element();
        int          r;
        logic [5:0]  code;
        logic [63:0] n;
        logic [63:0] plain;
        r = $urandom_range(0, 99);
        if (r < 40)
        begin
            n = pick_size();
            put_length(n, 1'b0);
            put_random_bytes(n);
        end
        else if (r < 65)
        begin
            code = 6'($urandom_range(0, 2));
            stim.push_back({TOP_ENC, code});
            put_random_bytes(code == ENC_INT32 ? 4 : code == ENC_INT16 ? 2 : 1);
        end
        else if (r < 88)
        begin
            n = pick_size();
            if ($urandom_range(0, 1) == 0)
                plain = pick_size();
            else
                plain = {$urandom(), $urandom()} >> $urandom_range(0, 63);
            stim.push_back({TOP_ENC, ENC_COMPRESSED});
            put_length(n, 1'b1);
            put_length(plain, 1'b1);
            put_random_bytes(n);
        end
        else
        begin
            case ($urandom_range(0, 3))
                0: stim.push_back({TOP_LONG, 6'($urandom_range(2, 63))});
                1: stim.push_back({TOP_ENC, 6'($urandom_range(4, 63))});
                2:
                begin
                    stim.push_back({TOP_ENC, ENC_COMPRESSED});
                    stim.push_back({TOP_LONG, 6'($urandom_range(2, 63))});
                end
                default:
                begin
                    stim.push_back({TOP_ENC, ENC_COMPRESSED});
                    put_length(pick_size(), 1'b1);
                    stim.push_back({TOP_LONG, 6'($urandom_range(2, 63))});
                end
            endcase
        end
    endfunction

    // Offer one byte after an optional gap; return at the falling edge after acceptance
    task automatic send_byte(logic [7:0] b, bit calm);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid             = 1'b1;
        in_ch.payload.data_byte = b;
        do
            @(posedge clk);
        while (!in_ch.ready);
        chk.take_byte(b);
        @(negedge clk);
    endtask

    // Check every result item taken at a rising edge
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            chk.compare_result(out_ch.payload);
    end

    // Result side: random stalls, calm stretches and one long hold-off
    initial
    begin : result_side
        int stall_left;
        int stretch_left;
        bit calm;
        bit held_long;
        out_ch.ready = 1'b0;
        stall_left   = 0;
        stretch_left = 0;
        calm         = 1'b0;
        held_long    = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held_long && chk.checked >= HOLD_AFTER)
            begin
                held_long    = 1'b1;
                out_ch.ready = 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end
            if (stretch_left == 0)
            begin
                stretch_left = $urandom_range(30, 150);
                calm         = ($urandom_range(0, 3) == 0);
            end
            stretch_left--;
            if (stall_left > 0)
            begin
                out_ch.ready = 1'b0;
                stall_left--;
            end
            else
            begin
                out_ch.ready = 1'b1;
                if (!calm)
                    stall_left = pick_gap();
            end
        end
    end

    // Stimulus
    initial
    begin : byte_source
        int stretch_left;
        bit calm;
        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        rst_n         = 1'b0;
        stretch_left  = 0;
        calm          = 1'b0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty raw, integer extremes, short raw, empty and
        // inner-coded compressed, then unknown long header and encoding codes
        stim = '{
            {TOP_LEN6, 6'd0},
            {TOP_ENC, ENC_INT8}, 8'h80,
            {TOP_ENC, ENC_INT16}, 8'hFF, 8'h7F,
            {TOP_ENC, ENC_INT32}, 8'h00, 8'h00, 8'h00, 8'h80,
            {TOP_LEN6, 6'd1}, 8'hFF,
            {TOP_ENC, ENC_COMPRESSED}, {TOP_LEN6, 6'd0}, {TOP_LEN6, 6'd5},
            {TOP_ENC, ENC_COMPRESSED}, {TOP_ENC, 6'd2}, {TOP_ENC, 6'h3F}, 8'h11, 8'h22,
            {TOP_LONG, 6'h3F}, {TOP_ENC, 6'h3F}, {TOP_ENC, 6'd4}
        };

        // Random elements, then a maximal 64-bit length left open at the end
        while (stim.size() < STIM_BYTES)
            add_element();
        stim.push_back(HDR_LEN64);
        repeat (8) stim.push_back(8'hFF);
        put_random_bytes(3);

        foreach (stim[i])
        begin
            if (stretch_left == 0)
            begin
                stretch_left = $urandom_range(40, 160);
                calm         = ($urandom_range(0, 3) == 0);
            end
            stretch_left--;
            send_byte(stim[i], calm);
        end
        in_ch.valid = 1'b0;

        // Drain
        while (chk.awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Covered %0d bytes: %0d raw, %0d integer and %0d compressed elements closed,",
                 chk.checked, chk.raw_seen, chk.int_seen, chk.lz_seen);
        $display("%0d unknown header codes, one %0d-cycle result stall.",
                 chk.bad_seen, LONG_HOLD);
        if (chk.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog
    initial
    begin : watchdog
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/rdbsep_pkg.sv
hw/rtl/rdbsep_stream_if.sv
hw/rtl/rdb_string_encoding_parser_core.sv
test/tb_rdb_string_encoding_parser_core.sv
